// ===== sv/sha1_hash_engine_defines.svh =====
// assertion macros for the sha1 hash engine
// used by the top level only, expects clk and rst in scope
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// condition that must hold in the same cycle as its trigger
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after its trigger
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sha1_pkg.sv =====
// shared types, constants and helpers for the sha1 hash engine
// no dependencies
package sha1_pkg;

  localparam int LEN_BITS  = 64;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int ROUNDS    = 80;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int BLK_WORDS = 16;
  localparam int WCNT_W    = $clog2(BLK_WORDS);

  localparam logic [2:0] FULL_BYTES = 3'd4;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [31:0] IV [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
  } sha1_item_t;

  typedef struct packed {
    logic        push;
    logic [31:0] push_word;
    logic        start;
    logic        reinit;
    logic [2:0]  rd_idx;
  } sha1_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] digest;
  } sha1_stat_t;

  // leading n bytes of a big-endian word
  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/sha1_front.sv =====
// input side of the sha1 hash engine: clamps byte count, clears unused bytes
// depends on sha1_pkg
module sha1_front
  import sha1_pkg::*;
(
  input  logic [31:0] s_axis_tdata,   // message_word
  input  logic [2:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        q_ready,
  output logic        q_push,
  output sha1_item_t  q_item
);

  logic [2:0] cnt;

  always_comb begin
    cnt = (s_axis_tuser > FULL_BYTES) ? FULL_BYTES : s_axis_tuser;
    q_item.cnt  = cnt;
    q_item.word = s_axis_tdata & byte_mask(cnt);
    q_item.last = s_axis_tlast;
  end

  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid & q_ready;

endmodule

// ===== sv/sha1_queue.sv =====
// short item queue between front and back of the sha1 hash engine
// depends on sha1_pkg
module sha1_queue
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sha1_item_t push_item,
  output logic       ready,
  input  logic       pop,
  output logic       valid,
  output sha1_item_t head
);

  sha1_item_t       slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;

  assign ready = (fill != QCW'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/sha1_core.sv =====
// sha1 compression unit: message schedule shift line, one round per cycle
// depends on sha1_pkg
module sha1_core
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sha1_ctrl_t ctrl,
  output sha1_stat_t stat
);

  logic [31:0]      win   [BLK_WORDS];
  logic [31:0]      rr    [5];
  logic [31:0]      chain [5];
  logic [RND_W-1:0] rnd;
  logic             running;
  logic             finishing;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] sx;
  logic [31:0] sched;

  always_comb begin
    priority if (rnd < RND_W'(20)) begin
      f = (rr[1] & rr[2]) | (~rr[1] & rr[3]);
      k = K0;
    end else if (rnd < RND_W'(40)) begin
      f = rr[1] ^ rr[2] ^ rr[3];
      k = K1;
    end else if (rnd < RND_W'(60)) begin
      f = (rr[1] & rr[2]) | (rr[1] & rr[3]) | (rr[2] & rr[3]);
      k = K2;
    end else begin
      f = rr[1] ^ rr[2] ^ rr[3];
      k = K3;
    end
    t     = {rr[0][26:0], rr[0][31:27]} + f + rr[4] + k + win[0];
    sx    = win[13] ^ win[8] ^ win[2] ^ win[0];
    sched = {sx[30:0], sx[31]};
  end

  assign stat.busy   = running | finishing;
  assign stat.digest = chain[ctrl.rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      finishing <= 1'b0;
      rnd       <= '0;
    end else if (ctrl.start) begin
      running <= 1'b1;
      rnd     <= '0;
    end else if (running) begin
      rnd <= rnd + 1'b1;
      if (rnd == RND_W'(ROUNDS - 1)) begin
        running   <= 1'b0;
        finishing <= 1'b1;
      end
    end else begin
      finishing <= 1'b0;
    end
  end

  // schedule window and working registers
  always_ff @(posedge clk) begin
    if (ctrl.push || running) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[BLK_WORDS - 1] <= running ? sched : ctrl.push_word;
    end
    if (ctrl.start) begin
      for (int i = 0; i < 5; i++) begin
        rr[i] <= chain[i];
      end
    end else if (running) begin
      rr[0] <= t;
      rr[1] <= rr[0];
      rr[2] <= {rr[1][1:0], rr[1][31:2]};
      rr[3] <= rr[2];
      rr[4] <= rr[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.reinit) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= IV[i];
      end
    end else if (finishing) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= chain[i] + rr[i];
      end
    end
  end

endmodule

// ===== sv/sha1_back.sv =====
// back part of the sha1 hash engine: byte packing, padding, digest output
// depends on sha1_pkg, drives sha1_core through a control struct
module sha1_back
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  sha1_item_t  q_item,
  output logic        q_pop,
  output sha1_ctrl_t  ctrl,
  input  sha1_stat_t  stat,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_number
  output logic        m_axis_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_ZERO  = 3'd3;
  localparam logic [2:0] S_LENHI = 3'd4;
  localparam logic [2:0] S_LENLO = 3'd5;
  localparam logic [2:0] S_COMP  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  logic [2:0]          state, state_next;
  logic [2:0]          ret, ret_next;
  logic [31:0]         acc, acc_next;
  logic [1:0]          acc_cnt, acc_cnt_next;
  logic [WCNT_W-1:0]   word_cnt, word_cnt_next;
  logic [LEN_BITS-1:0] bit_length, bit_length_next;
  logic [2:0]          idx, idx_next;

  logic [31:0] acc_m;
  logic [31:0] src_word;
  logic [2:0]  src_cnt;
  logic [63:0] comb;
  logic [2:0]  total;
  logic        merge_full;
  logic [63:0] len64;
  logic        do_push;
  logic [31:0] push_word;
  logic        out_load;

  always_comb begin
    acc_m      = acc & byte_mask({1'b0, acc_cnt});
    src_word   = (state == S_PAD) ? PAD_WORD : q_item.word;
    src_cnt    = (state == S_PAD) ? 3'd1 : q_item.cnt;
    comb       = {acc_m, 32'h0} | ({src_word, 32'h0} >> {acc_cnt, 3'b000});
    total      = {1'b0, acc_cnt} + src_cnt;
    merge_full = (total >= FULL_BYTES);
    len64      = 64'(bit_length);
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    acc_next        = acc;
    acc_cnt_next    = acc_cnt;
    word_cnt_next   = word_cnt;
    bit_length_next = bit_length;
    idx_next        = idx;
    q_pop           = 1'b0;
    do_push         = 1'b0;
    push_word       = '0;
    out_load        = 1'b0;
    ctrl            = '0;
    ctrl.rd_idx     = idx;

    unique case (state)
      S_IDLE, S_PAD: begin
        if (state == S_PAD || q_valid) begin
          do_push      = merge_full;
          push_word    = comb[63:32];
          acc_next     = merge_full ? comb[31:0] : comb[63:32];
          acc_cnt_next = merge_full ? 2'(total - FULL_BYTES) : 2'(total);
          if (state == S_PAD) begin
            state_next = S_FLUSH;
          end else begin
            q_pop           = 1'b1;
            bit_length_next = bit_length + LEN_BITS'({q_item.cnt, 3'b000});
            state_next      = q_item.last ? S_PAD : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        do_push      = (acc_cnt != 2'd0);
        push_word    = acc_m;
        acc_cnt_next = 2'd0;
        state_next   = S_ZERO;
      end
      S_ZERO: begin
        if (word_cnt == WCNT_W'(BLK_WORDS - 2)) begin
          state_next = S_LENHI;
        end else begin
          do_push = 1'b1;
        end
      end
      S_LENHI: begin
        do_push    = 1'b1;
        push_word  = len64[63:32];
        state_next = S_LENLO;
      end
      S_LENLO: begin
        do_push    = 1'b1;
        push_word  = len64[31:0];
        state_next = S_OUT;
      end
      S_COMP: begin
        if (!stat.busy) begin
          state_next = ret;
        end
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          if (idx == WORD_LAST) begin
            ctrl.reinit     = 1'b1;
            bit_length_next = '0;
            idx_next        = '0;
            state_next      = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    ctrl.push      = do_push;
    ctrl.push_word = push_word;
    ctrl.start     = do_push && (word_cnt == WCNT_W'(BLK_WORDS - 1));
    if (do_push) begin
      word_cnt_next = word_cnt + 1'b1;
    end
    if (ctrl.start) begin
      ret_next   = state_next;
      state_next = S_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      acc_cnt    <= 2'd0;
      word_cnt   <= '0;
      bit_length <= '0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      acc_cnt    <= acc_cnt_next;
      word_cnt   <= word_cnt_next;
      bit_length <= bit_length_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= stat.digest;
      m_axis_tuser <= idx;
      m_axis_tlast <= (idx == WORD_LAST);
    end
  end

endmodule

// ===== sv/sha1_hash_engine.sv =====
// top level of the streaming sha1 hash engine
// depends on sha1_pkg, sha1_front, sha1_queue, sha1_back, sha1_core
//
// channel  dir  tdata          tuser          tlast
// s_axis   in   message_word   valid_bytes    last_word
// m_axis   out  digest_word    word_number    digest_done
//
// a full 64-byte block is compressed round by round, starting with its sixteenth word
// a last word adds padding, one or two compressions, then 5 digest items
// the four-entry queue keeps taking items while the back part compresses
// rst is synchronous; chaining words return to the initial vector after each digest
`include "sha1_hash_engine_defines.svh"

module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // message_word
  input  logic [2:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_number
  output logic        m_axis_tlast
);

  sha1_item_t in_item;
  sha1_item_t q_head;
  logic       q_push;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;
  sha1_ctrl_t ctrl;
  sha1_stat_t stat;

  sha1_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_item        (in_item)
  );

  sha1_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  sha1_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .ctrl          (ctrl),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha1_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // no schedule word may enter while rounds are running
  `SHA1_ASSERT_NOW(a_push_idle, ctrl.push, !stat.busy, "word pushed during compression")
  // a compression starts only with the block's sixteenth word
  `SHA1_ASSERT_NOW(a_start_push, ctrl.start, ctrl.push, "compression started without a word")
  // the queue is never popped when empty
  `SHA1_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  // a stalled digest item stays offered and unchanged
  `SHA1_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}),
                    "stalled digest item changed")

endmodule
